### src/plbp_pkg.sv
// package for the piecewise linear branch predictor
// holds table sizes, weight limits and the saturating weight step; no dependencies
`default_nettype none
package plbp_pkg;
  localparam int unsigned WeightW = 8;
  localparam int unsigned SumW    = 15;
  localparam int unsigned ThreshW = 14;
  localparam int unsigned AddrW   = 64;
  // row and column counts, powers of two so that selection is a mask
  localparam int unsigned Rows    = 8;
  localparam int unsigned Cols    = 64;
  localparam int unsigned RowW    = (Rows > 1) ? $clog2(Rows) : 1;
  localparam int unsigned ColW    = $clog2(Cols);
  localparam logic signed [WeightW-1:0] WMax = 8'sd127;
  localparam logic signed [WeightW-1:0] WMin = -8'sd127;

  // saturating step of one weight
  function automatic logic signed [WeightW-1:0] bump(logic signed [WeightW-1:0] w,
                                                    logic up);
    logic signed [WeightW-1:0] r;
    r = w;
    if (up) begin
      if (w < WMax) r = w + 8'sd1;
    end else begin
      if (w > WMin) r = w - 8'sd1;
    end
    return r;
  endfunction
endpackage
`default_nettype wire

### src/piecewise_linear_branch_predictor_top.sv
// piecewise linear branch predictor: one cell per history position plus bias bank
// per branch: read, sum accumulated one cell at a time along the row, update, output
// a new branch is taken only when idle, after the last result is accepted; the sum walks the cell row
// reset: histories cleared at once, then the clear state zeroes every entry of all weight banks
// before the first branch is taken; threshold resets to 57
// depends on plbp_pkg, plbp_cell
`default_nettype none
module piecewise_linear_branch_predictor_top import plbp_pkg::*; #(
  parameter int unsigned HIST = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [71:0] s_axis_tdata,   // address[63:0], taken[64], zero fill
  input  wire logic        m_axis_tready,
  output logic             m_axis_tvalid,
  output logic [23:0]      m_axis_tdata,   // prediction[0], sum[15:1], trained[16]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [13:0] cfg_data_i
);
  localparam int unsigned RW = RowW;
  localparam int unsigned CW = ColW;
  localparam int unsigned Depth = Rows * Cols;
  localparam int unsigned DW = $clog2(Depth + 1);
  localparam int unsigned HW = $clog2(HIST + 2);
  localparam int unsigned IW = (HIST > 1) ? $clog2(HIST) : 1;

  localparam logic [2:0] StClr = 3'd0, StIdle = 3'd1, StRd = 3'd2, StSum = 3'd3,
                         StUpd = 3'd4, StOut = 3'd5;
  logic [2:0] st_q, st_d;
  logic [DW-1:0] clr_q;
  logic [HW-1:0] cnt_q;
  logic [ThreshW-1:0] thr_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic tk_q, train;
  logic signed [SumW-1:0] acc_q;
  logic signed [WeightW-1:0] bias_mem [Depth];
  logic signed [WeightW-1:0] bias_q;
  logic [RW+CW-1:0] bidx_q;
  logic [RW-1:0] row_in;
  logic [CW-1:0] col_in;

  logic signed [SumW-1:0] sums [HIST];
  logic [CW-1:0] cols [HIST+1];
  logic outs [HIST+1];
  logic clr, rd, wr, shift;
  logic signed [SumW-1:0] fin;
  logic [SumW-1:0] mag;

  assign row_in = s_axis_tdata[RW-1:0];
  assign col_in = s_axis_tdata[CW-1:0];
  assign clr = (st_q == StClr);
  assign rd = (st_q == StIdle) && s_axis_tvalid;
  assign wr = (st_q == StUpd) && train;
  assign shift = (st_q == StUpd);
  assign cols[0] = col_q;
  assign outs[0] = tk_q;
  assign s_axis_tready = (st_q == StIdle);
  assign cfg_ready_o = 1'b1;

  // row of history cells, history passed along the chain, sum accumulated in acc_q one cell at a time
  for (genvar g = 0; g < HIST; g++) begin : g_cell
    plbp_cell u_cell (
      .clk_i, .rst_ni, .clr_i(clr), .clr_addr_i(clr_q[RW+CW-1:0]), .rd_i(rd),
      .row_i(rd ? row_in : row_q), .wr_i(wr), .tk_i(tk_q), .shift_i(shift),
      .col_in_i(cols[g]), .out_in_i(outs[g]), .sum_in_i(acc_q),
      .sum_o(sums[g]), .col_o(cols[g+1]), .out_o(outs[g+1])
    );
  end

  assign fin = acc_q;
  assign mag = fin[SumW-1] ? -fin : fin;

  // bias bank
  always_ff @(posedge clk_i) begin
    if (clr) begin
      bias_mem[clr_q[RW+CW-1:0]] <= '0;
    end else if (wr) begin
      bias_mem[bidx_q] <= bump(bias_q, tk_q);
    end
    if (rd) begin
      bias_q <= bias_mem[{row_in, col_in}];
      bidx_q <= {row_in, col_in};
    end
  end

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      StClr:  if (clr_q == DW'(Depth - 1)) st_d = StIdle;
      StIdle: if (s_axis_tvalid) st_d = StRd;
      StRd:   st_d = (HIST == 0) ? StUpd : StSum;
      StSum:  if (cnt_q == HW'(HIST - 1)) st_d = StUpd;
      StUpd:  st_d = StOut;
      StOut:  if (m_axis_tready) st_d = StIdle;
      default: st_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClr;
      clr_q <= '0;
      cnt_q <= '0;
      thr_q <= 14'd57;
      m_axis_tvalid <= 1'b0;
    end else begin
      st_q <= st_d;
      if (cfg_valid_i) thr_q <= cfg_data_i;
      if (clr) clr_q <= clr_q + 1'b1;
      if (st_q == StRd) cnt_q <= '0;
      else if (st_q == StSum) cnt_q <= cnt_q + 1'b1;
      if (st_q == StUpd) m_axis_tvalid <= 1'b1;
      else if (m_axis_tready) m_axis_tvalid <= 1'b0;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (rd) begin
      row_q <= row_in;
      col_q <= col_in;
      tk_q <= s_axis_tdata[64];
    end
    if (st_q == StRd) acc_q <= SumW'(bias_q);
    if (st_q == StSum) acc_q <= sums[cnt_q[IW-1:0]];
    if (st_q == StUpd) begin
      m_axis_tdata <= {7'd0, train, fin, ~fin[SumW-1]};
    end
  end

  // train on a miss or while the magnitude is below the threshold
  assign train = (~fin[SumW-1] != tk_q) || ({1'b0, mag[ThreshW-1:0]} < {1'b0, thr_q}
                 && mag[SumW-1:ThreshW] == '0);
endmodule
`default_nettype wire

### src/plbp_cell.sv
// one history position: its weight bank, its path and outcome history entry
// depends on plbp_pkg
`default_nettype none
module plbp_cell import plbp_pkg::*; (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   clr_i,
  input  wire logic [RowW+ColW-1:0]   clr_addr_i,
  input  wire logic                   rd_i,
  input  wire logic [RowW-1:0]        row_i,
  input  wire logic                   wr_i,
  input  wire logic                   tk_i,
  input  wire logic                   shift_i,
  input  wire logic [ColW-1:0]        col_in_i,
  input  wire logic                   out_in_i,
  input  wire logic signed [SumW-1:0] sum_in_i,
  output logic signed [SumW-1:0]      sum_o,
  output logic [ColW-1:0]             col_o,
  output logic                        out_o
);
  localparam int unsigned Depth = Rows * Cols;
  logic signed [WeightW-1:0] mem [Depth];
  logic signed [WeightW-1:0] rd_q;
  logic [RowW+ColW-1:0] idx_q;
  logic [ColW-1:0] col_q;
  logic out_q;
  logic [RowW+ColW-1:0] idx;

  assign idx = {row_i, col_q};

  // weight bank, read then write back the same entry
  always_ff @(posedge clk_i) begin
    if (clr_i) begin
      mem[clr_addr_i] <= '0;
    end else if (wr_i) begin
      mem[idx_q] <= bump(rd_q, out_q == tk_i);
    end
    if (rd_i) begin
      rd_q  <= mem[idx];
      idx_q <= idx;
    end
  end

  // history entry, handed on to the next cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      out_q <= 1'b0;
    end else if (shift_i) begin
      col_q <= col_in_i;
      out_q <= out_in_i;
    end
  end

  assign sum_o = out_q ? sum_in_i + SumW'(rd_q) : sum_in_i - SumW'(rd_q);
  assign col_o = col_q;
  assign out_o = out_q;
endmodule
`default_nettype wire

### tb/piecewise_linear_branch_predictor_top_tb.sv
// testbench for the piecewise linear branch predictor top level
// self-checking: an internal predictor follows every branch transfer; needs plbp_pkg and the dut
`default_nettype none
module piecewise_linear_branch_predictor_top_tb import plbp_pkg::*;;

  localparam int unsigned NRows = Rows;
  localparam int unsigned NCols = Cols;
  localparam int unsigned NHist = 16;
  localparam int unsigned NRandom = 1192;
  localparam int unsigned HoldCycles = 200;

  typedef struct packed {
    logic               trained;
    logic signed [14:0] sum;
    logic               prediction;
  } outcome_t;

  typedef struct {
    logic [63:0] address;
    logic        taken;
    logic        known;      // expected result typed in
    outcome_t    result;
  } branch_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata = '0;
  logic        m_axis_tready = 1'b0;
  logic        m_axis_tvalid;
  logic [23:0] m_axis_tdata;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [13:0] cfg_data_i = '0;

  piecewise_linear_branch_predictor_top #(
    .HIST(NHist)
  ) i_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tready(m_axis_tready), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid_i(cfg_valid_i), .cfg_ready_o(cfg_ready_o), .cfg_data_i(cfg_data_i)
  );

  // predictor state
  logic signed [7:0] wt [NRows][NCols][NHist+1];
  logic [5:0]        path_hist [NHist];
  logic              dir_hist [NHist];
  logic [13:0]       threshold;

  outcome_t    pending_outcomes [$];
  int unsigned mismatches = 0;
  bit          hold_request = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic signed [7:0] step_weight(logic signed [7:0] w, logic up);
    if (up) return (w < 8'sd127) ? w + 8'sd1 : w;
    return (w > -8'sd127) ? w - 8'sd1 : w;
  endfunction

  // work out one branch and train the shadow weights
  function automatic outcome_t predict_branch(logic [63:0] address, logic taken);
    int unsigned row, col;
    int          acc;
    int          mag;
    outcome_t    res;
    row = 32'(address % NRows);
    col = 32'(address % NCols);
    acc = int'(wt[row][col][0]);
    for (int i = 0; i < NHist; i++)
      acc += dir_hist[i] ? int'(wt[row][path_hist[i]][i+1])
                         : -int'(wt[row][path_hist[i]][i+1]);
    res.prediction = (acc >= 0);
    mag = (acc < 0) ? -acc : acc;
    res.trained = (res.prediction != taken) || (mag < int'(threshold));
    res.sum = acc[14:0];
    if (res.trained) begin
      wt[row][col][0] = step_weight(wt[row][col][0], taken);
      for (int i = 0; i < NHist; i++)
        wt[row][path_hist[i]][i+1] =
          step_weight(wt[row][path_hist[i]][i+1], dir_hist[i] == taken);
    end
    for (int i = NHist - 1; i > 0; i--) begin
      path_hist[i] = path_hist[i-1];
      dir_hist[i]  = dir_hist[i-1];
    end
    path_hist[0] = col[5:0];
    dir_hist[0]  = taken;
    return res;
  endfunction

  task automatic report_mismatch(string what, outcome_t exp_r, outcome_t got_r);
    mismatches++;
    if (mismatches <= 10)
      $display("%s: expected pred %0b sum %0d trained %0b, got pred %0b sum %0d trained %0b",
               what, exp_r.prediction, exp_r.sum, exp_r.trained,
               got_r.prediction, got_r.sum, got_r.trained);
  endtask

  task automatic wait_cycles(int unsigned n);
    repeat (n) @(negedge clk_i);
  endtask

  task automatic wait_drained();
    while (pending_outcomes.size() != 0) @(negedge clk_i);
    wait_cycles(NHist + 8);
  endtask

  task automatic write_threshold(logic [13:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    threshold = value;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // offer one branch, keeping valid high into the next one when there is no gap
  task automatic send_branch(logic [63:0] address, logic taken, int unsigned gap,
                             logic known, outcome_t typed);
    outcome_t res;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      wait_cycles(gap);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, taken, address};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    res = predict_branch(address, taken);
    if (known && res != typed) report_mismatch("typed row", typed, res);
    pending_outcomes.push_back(res);
    @(negedge clk_i);
  endtask

  task automatic idle_input();
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [63:0] rand_address();
    return {$urandom(), $urandom()};
  endfunction

  // sender wait before one branch, none while the block warms up
  function automatic int unsigned pick_gap(int k);
    if (k < 200) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 4);
  endfunction

  // directed rows: reset state and extreme addresses
  branch_row_t directed_rows [] = '{
    '{64'h0, 1'b1, 1'b1, '{1'b1, 15'sd0, 1'b1}},
    '{64'hFFFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, '0},
    '{64'h0, 1'b0, 1'b0, '0},
    '{64'h8000_0000_0000_0000, 1'b1, 1'b0, '0},
    '{64'h7FFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, '0},
    '{64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, '0},
    '{64'h5555_5555_5555_5555, 1'b1, 1'b0, '0},
    '{64'h0000_0000_0000_003F, 1'b1, 1'b0, '0},
    '{64'h0000_0000_0000_0007, 1'b0, 1'b0, '0},
    '{64'h1234_5678_9ABC_DEF0, 1'b1, 1'b0, '0}
  };

  // result checker and receiver stalls
  initial begin
    outcome_t got;
    int unsigned stall;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
        hold_request = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        wait_cycles(stall);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      got = outcome_t'(m_axis_tdata[16:0]);
      if (pending_outcomes.size() == 0) begin
        report_mismatch("unexpected result", '0, got);
      end else begin
        outcome_t exp_r;
        exp_r = pending_outcomes.pop_front();
        if (got.prediction !== exp_r.prediction || got.sum !== exp_r.sum ||
            got.trained !== exp_r.trained)
          report_mismatch("result", exp_r, got);
      end
    end
  end

  // stimulus
  initial begin
    logic [63:0] base;
    int unsigned loop_len;
    int unsigned next_phase;
    int unsigned phase;
    bit          hold_issued;
    for (int r = 0; r < NRows; r++)
      for (int c = 0; c < NCols; c++)
        for (int h = 0; h <= NHist; h++) wt[r][c][h] = '0;
    for (int i = 0; i < NHist; i++) begin
      path_hist[i] = '0;
      dir_hist[i]  = 1'b0;
    end
    threshold = 14'd57;
    next_phase = 329;
    phase = 0;
    hold_issued = 1'b0;
    wait_cycles(11);
    rst_ni <= 1'b1;

    foreach (directed_rows[k])
      send_branch(directed_rows[k].address, directed_rows[k].taken, 0,
                  directed_rows[k].known, directed_rows[k].result);
    // one branch hammered taken, its weights trained only while its sum stays below the threshold
    for (int k = 0; k < 140; k++) send_branch(64'h40, 1'b1, 0, 1'b0, '0);
    idle_input();
    wait_drained();

    // only mispredictions train at threshold zero
    write_threshold(14'd0);
    for (int k = 0; k < 8; k++) send_branch(64'h40, k[0], 0, 1'b0, '0);
    idle_input();
    wait_drained();
    write_threshold(14'h3FFF);

    for (int k = 0; k < NRandom; k++) begin
      // phase changes: threshold sweep with a drained block
      if (k >= next_phase) begin
        idle_input();
        wait_drained();
        case (phase % 4)
          0: write_threshold(14'($urandom_range(0, 200)));
          1: write_threshold(14'd8320);
          2: write_threshold(14'($urandom()));
          default: write_threshold(14'd57);
        endcase
        phase++;
        next_phase += 330;
      end
      if (k >= 500 && !hold_issued) begin
        hold_request = 1'b1;
        hold_issued = 1'b1;
      end
      // mostly small loops of correlated branches, some noise
      if ($urandom_range(0, 3) != 0) begin
        base = rand_address();
        loop_len = $urandom_range(2, 6);
        for (int j = 0; j < loop_len && k < NRandom; j++) begin
          send_branch(base + 64'(j * 4), (j % 2 == 0) ^ (loop_len > 4), pick_gap(k),
                      1'b0, '0);
          k++;
        end
        k--;
      end else begin
        send_branch(rand_address(), 1'($urandom()), pick_gap(k), 1'b0, '0);
      end
    end
    idle_input();
    wait_drained();
    if (mismatches == 0 && pending_outcomes.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run limit
  initial begin
    #(12 * 600000);
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire
